### src/fust_pkg.sv
// shared types and constants for the first unique symbol tracker
`timescale 1ns / 1ps

package fust_pkg;

    // width of one symbol code
    localparam int SYM_W = 5;

    // default number of distinct symbols (letters a to z)
    localparam int ALPHABET_SIZE_DEF = 26;

    // per-transfer control broadcast to every cell
    typedef struct packed {
        logic step;    // an input transfer happens this cycle
        logic clear;   // start of a new stream, wipe state first
        logic append;  // symbol joins the tail of the list
        logic remove;  // symbol leaves the list, later entries move up
    } ctl_t;

    // one result item
    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] first_symbol;
    } res_t;

endpackage

### src/first_unique_symbol_tracker_top.sv
// first unique symbol tracker: reports the oldest symbol seen exactly once
//
// input channel s_axis_*: one symbol per transfer in tdata, tuser set starts a
// new stream and clears all history before that symbol is handled.
// output channel m_axis_*: one result per input transfer, in order; tuser is
// the found flag, tdata the oldest symbol seen exactly once (zero if none).
// symbols at or above ALPHABET_SIZE leave the state unchanged.
// throughput: one symbol per cycle while s_axis_tready is high; the list is a
// row of ALPHABET_SIZE cells that shift up by one on a removal and fill at the
// tail on an append, all in the cycle of the transfer.
// the result is registered in the output register, or in the skid stage while that is busy.
// a two-entry output buffer lets input continue while one result waits; with
// the receiver stalled, s_axis_tready drops after two results are held.
// reset clears the list, the repeated flags and the output buffer at once;
// the block is ready for input as soon as reset is released.
`timescale 1ns / 1ps

module first_unique_symbol_tracker_top
    import fust_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] symbol, [7:5] zero
    input  logic       s_axis_tuser,   // [0] start_req
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] first_symbol, [7:5] zero
    output logic       m_axis_tuser    // [0] found
);

    logic             in_fire;
    logic [SYM_W-1:0] symbol;
    logic             in_range;
    ctl_t             ctl;
    logic             rep_any;
    logic             in_list;
    logic             list_full;
    res_t             res;
    res_t             out_res;

    logic [ALPHABET_SIZE-1:0] rep_hit;
    logic [ALPHABET_SIZE-1:0] cell_valid;
    logic [ALPHABET_SIZE-1:0] cell_shift;
    logic [SYM_W-1:0]         cell_sym [ALPHABET_SIZE];

    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign symbol    = s_axis_tdata[SYM_W-1:0];
    assign in_range  = (int'(symbol) < ALPHABET_SIZE);

    // decide what this transfer does to the list
    assign rep_any   = |rep_hit;
    assign in_list   = cell_shift[ALPHABET_SIZE-1];
    assign list_full = cell_valid[ALPHABET_SIZE-1];

    assign ctl.step   = in_fire;
    assign ctl.clear  = s_axis_tuser;
    assign ctl.remove = in_range & ~rep_any & in_list;
    assign ctl.append = in_range & ~rep_any & ~in_list & ~list_full;

    // repeated flags, one cell per symbol code
    for (genvar k = 0; k < ALPHABET_SIZE; k++)
    begin : g_flag
        fust_flag_cell #(
            .INDEX (k)
        ) u_flag (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .symbol  (symbol),
            .rep_hit (rep_hit[k])
        );
    end

    // ordered list, cell 0 is the oldest entry
    for (genvar i = 0; i < ALPHABET_SIZE; i++)
    begin : g_list
        logic             prev_valid;
        logic             prev_shift;
        logic             next_valid;
        logic [SYM_W-1:0] next_sym;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
            assign prev_shift = 1'b0;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
            assign prev_shift = cell_shift[i-1];
        end

        if (i == ALPHABET_SIZE - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_sym   = '0;
        end
        else
        begin : g_inner
            assign next_valid = cell_valid[i+1];
            assign next_sym   = cell_sym[i+1];
        end

        if (i == 0)
        begin : g_cell_head
            fust_list_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .symbol     (symbol),
                .prev_valid (prev_valid),
                .prev_shift (prev_shift),
                .next_valid (next_valid),
                .next_sym   (next_sym),
                .valid      (cell_valid[i]),
                .sym        (cell_sym[i]),
                .shift      (cell_shift[i]),
                .valid_next (res.found),
                .sym_next   (res.first_symbol)
            );
        end
        else
        begin : g_cell
            fust_list_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .symbol     (symbol),
                .prev_valid (prev_valid),
                .prev_shift (prev_shift),
                .next_valid (next_valid),
                .next_sym   (next_sym),
                .valid      (cell_valid[i]),
                .sym        (cell_sym[i]),
                .shift      (cell_shift[i]),
                .valid_next (),
                .sym_next   ()
            );
        end
    end

    // result buffer toward the output channel
    fust_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .res       (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // first_symbol reads as zero when nothing is found
    assign m_axis_tuser = out_res.found;
    assign m_axis_tdata = {{(8 - SYM_W){1'b0}},
                           out_res.first_symbol & {SYM_W{out_res.found}}};

endmodule

### src/fust_list_cell.sv
// one entry of the arrival-ordered list of symbols seen exactly once
`timescale 1ns / 1ps

module fust_list_cell
    import fust_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  logic [SYM_W-1:0] symbol,
    input  logic             prev_valid,   // left neighbor holds an entry
    input  logic             prev_shift,   // removed entry lies left of this cell
    input  logic             next_valid,   // right neighbor holds an entry
    input  logic [SYM_W-1:0] next_sym,     // right neighbor's entry
    output logic             valid,        // entry present after a stream start
    output logic [SYM_W-1:0] sym,
    output logic             shift,        // removed entry lies at or left of here
    output logic             valid_next,
    output logic [SYM_W-1:0] sym_next
);

    logic             valid_reg;
    logic [SYM_W-1:0] sym_reg;
    logic             match;

    // current contents as seen by this transfer
    assign valid = valid_reg & ~ctl.clear;
    assign sym   = sym_reg;
    assign match = valid & (sym_reg == symbol);
    assign shift = prev_shift | match;

    // update: move up on removal, take the symbol at the tail on append
    always_comb
    begin
        valid_next = valid;
        sym_next   = sym_reg;
        if (ctl.remove && shift)
        begin
            valid_next = next_valid;
            sym_next   = next_sym;
        end
        else if (ctl.append && !valid && prev_valid)
        begin
            valid_next = 1'b1;
            sym_next   = symbol;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            sym_reg <= sym_next;
        end
    end

endmodule

### src/fust_flag_cell.sv
// repeated flag for one symbol code
`timescale 1ns / 1ps

module fust_flag_cell
    import fust_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  logic [SYM_W-1:0] symbol,
    output logic             rep_hit   // incoming symbol is this one and has repeated
);

    logic rep_reg;
    logic rep_cur;
    logic hit;

    assign hit     = (int'(symbol) == INDEX);
    assign rep_cur = rep_reg & ~ctl.clear;
    assign rep_hit = hit & rep_cur;

    // set on the second sighting, wiped at a stream start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            rep_reg <= rep_cur | (hit & ctl.remove);
        end
    end

endmodule

### src/fust_out_buf.sv
// two-entry output buffer: output register plus skid stage
`timescale 1ns / 1ps

module fust_out_buf
    import fust_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,     // a result is produced this cycle
    input  res_t res,
    output logic in_ready,    // room for one more result
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic out_free;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = ~out_valid_reg | out_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_fire;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg  <= skid_res_reg;
                skid_res_reg <= res;
            end
            else
            begin
                out_res_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_res_reg <= res;
        end
    end

endmodule
